// ===== hw/rtl/bc1_pkg.sv =====
// bc1_pkg: shared types, constants and color helpers of the BC1 block decoder.
// No dependencies; the palette pipeline, the block decoder and the bench take names from here.
`timescale 1ns / 1ps
`default_nettype none

package bc1_pkg;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [1:0] ROW_LAST     = 2'd3;
  localparam int unsigned PIXEL_W     = 32;
  localparam int unsigned ROW_IDX_W   = 8;

  typedef logic [PIXEL_W-1:0] pixel_t;

  // One compressed block as it enters the palette pipeline
  typedef struct packed {
    logic [15:0] endpoint_first;
    logic [15:0] endpoint_second;
    logic [31:0] index_bits;
  } blk_t;

  // Finished palette plus the indices that pick from it
  typedef struct packed {
    pixel_t [3:0] pal;
    logic [31:0]  index_bits;
  } pal_blk_t;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // floor(x / 3) for x < 768 as x * 683 >> 11
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = {11'd0, x} * 21'd683;
    return p[18:11];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bc1_if.sv =====
// bc1_in_if / bc1_out_if: valid/ready channels of the BC1 block decoder.
// Payload widths are fixed by the block and row formats; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface bc1_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] endpoint_first;
  logic [15:0] endpoint_second;
  logic [31:0] index_bits;

  modport source(output valid, endpoint_first, endpoint_second, index_bits, input ready);
  modport sink(input valid, endpoint_first, endpoint_second, index_bits, output ready);
endinterface

interface bc1_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  row_number;
  logic [31:0] pixel_left;
  logic [31:0] pixel_second;
  logic [31:0] pixel_third;
  logic [31:0] pixel_right;
  logic        last_row;

  modport source(output valid, row_number, pixel_left, pixel_second, pixel_third,
                 pixel_right, last_row, input ready);
  modport sink(input valid, row_number, pixel_left, pixel_second, pixel_third,
               pixel_right, last_row, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bc1_pal_pipe.sv =====
// bc1_pal_pipe: three-stage elastic pipeline that turns a block into its palette.
// Depends on bc1_pkg for the block and palette types and the color helpers.
`timescale 1ns / 1ps
`default_nettype none

module bc1_pal_pipe (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire bc1_pkg::blk_t     in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output bc1_pkg::pal_blk_t      out_data
);

  // Stage 1: widened endpoints, mode bit
  logic        s1_v_r;
  logic [7:0]  s1_a_r [3];
  logic [7:0]  s1_b_r [3];
  logic        s1_four_r;
  logic [31:0] s1_idx_r;

  // Stage 2: weighted sums
  logic        s2_v_r;
  logic [7:0]  s2_a_r [3];
  logic [7:0]  s2_b_r [3];
  logic [9:0]  s2_2ab_r [3];
  logic [9:0]  s2_a2b_r [3];
  logic [8:0]  s2_ab_r [3];
  logic        s2_four_r;
  logic [31:0] s2_idx_r;

  // Stage 3: palette
  logic              s3_v_r;
  bc1_pkg::pal_blk_t s3_r;

  logic s1_en, s2_en, s3_en;

  assign s3_en    = !s3_v_r || out_ready;
  assign s2_en    = !s2_v_r || s3_en;
  assign s1_en    = !s1_v_r || s2_en;
  assign in_ready = s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s1_en) s1_v_r <= in_valid;
      if (s2_en) s2_v_r <= s1_v_r;
      if (s3_en) s3_v_r <= s2_v_r;
    end
  end

  // Channel order in the arrays: 0 blue, 1 green, 2 red
  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_a_r[0] <= bc1_pkg::widen5(in_data.endpoint_first[4:0]);
      s1_a_r[1] <= bc1_pkg::widen6(in_data.endpoint_first[10:5]);
      s1_a_r[2] <= bc1_pkg::widen5(in_data.endpoint_first[15:11]);
      s1_b_r[0] <= bc1_pkg::widen5(in_data.endpoint_second[4:0]);
      s1_b_r[1] <= bc1_pkg::widen6(in_data.endpoint_second[10:5]);
      s1_b_r[2] <= bc1_pkg::widen5(in_data.endpoint_second[15:11]);
      s1_four_r <= in_data.endpoint_first > in_data.endpoint_second;
      s1_idx_r  <= in_data.index_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      for (int c = 0; c < 3; c++) begin
        s2_a_r[c]   <= s1_a_r[c];
        s2_b_r[c]   <= s1_b_r[c];
        s2_2ab_r[c] <= {1'b0, s1_a_r[c], 1'b0} + {2'b00, s1_b_r[c]};
        s2_a2b_r[c] <= {2'b00, s1_a_r[c]} + {1'b0, s1_b_r[c], 1'b0};
        s2_ab_r[c]  <= {1'b0, s1_a_r[c]} + {1'b0, s1_b_r[c]};
      end
      s2_four_r <= s1_four_r;
      s2_idx_r  <= s1_idx_r;
    end
  end

  logic [7:0] p2 [3];
  logic [7:0] p3 [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (s2_four_r) begin
        p2[c] = bc1_pkg::div3(s2_2ab_r[c]);
        p3[c] = bc1_pkg::div3(s2_a2b_r[c]);
      end else begin
        p2[c] = s2_ab_r[c][8:1];
        p3[c] = 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en) begin
      s3_r.pal[0] <= {bc1_pkg::ALPHA_OPAQUE, s2_a_r[2], s2_a_r[1], s2_a_r[0]};
      s3_r.pal[1] <= {bc1_pkg::ALPHA_OPAQUE, s2_b_r[2], s2_b_r[1], s2_b_r[0]};
      s3_r.pal[2] <= {bc1_pkg::ALPHA_OPAQUE, p2[2], p2[1], p2[0]};
      // Transparent black in three-color mode
      s3_r.pal[3] <= s2_four_r ? {bc1_pkg::ALPHA_OPAQUE, p3[2], p3[1], p3[0]} : 32'h0;
      s3_r.index_bits <= s2_idx_r;
    end
  end

  assign out_valid = s3_v_r;
  assign out_data  = s3_r;

  a_s1_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_v_r)
    else $error("accepted block did not enter stage 1");

  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && !out_ready |=> s3_v_r && $stable(s3_r))
    else $error("stalled palette changed");

  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |-> s3_r.pal[0][31:24] == bc1_pkg::ALPHA_OPAQUE)
    else $error("endpoint color not opaque");

endmodule

`default_nettype wire

// ===== hw/rtl/bc1_block_decoder.sv =====
// bc1_block_decoder: a taken block passes pipeline stages 1 to 3, then the row serializer
// register, and its rows follow one per cycle while out_row.ready holds. The block rate is
// set by the row serializer emitting one 4-pixel row per cycle while out_row.ready holds.
// A new block enters every cycle until the three stages and the serializer hold four.
// Synchronous active-low reset clears all valid bits; payload registers keep junk.
// Depends on bc1_pkg, bc1_if (channels) and bc1_pal_pipe.
`timescale 1ns / 1ps
`default_nettype none

module bc1_block_decoder (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bc1_in_if.sink     in_blk,
  bc1_out_if.source  out_row
);

  bc1_pkg::blk_t     blk;
  bc1_pkg::pal_blk_t pipe_data;
  logic              pipe_valid;
  logic              pipe_ready;

  assign blk.endpoint_first  = in_blk.endpoint_first;
  assign blk.endpoint_second = in_blk.endpoint_second;
  assign blk.index_bits      = in_blk.index_bits;

  // Palette build: widen, sum, divide and select over three stages
  bc1_pal_pipe u_pal_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_blk.valid),
    .in_ready  (in_blk.ready),
    .in_data   (blk),
    .out_valid (pipe_valid),
    .out_ready (pipe_ready),
    .out_data  (pipe_data)
  );

  // Row serializer: hold one palette, advance one row per output transaction.
  // The index word shifts right by one row each step, so the current row is
  // always in its low byte.
  logic                   ser_v_r, ser_v_nxt;
  logic [1:0]             row_r, row_nxt;
  bc1_pkg::pixel_t [3:0]  pal_r;
  logic [31:0]            idx_r, idx_nxt;
  logic                   ser_load;
  logic                   row_done;

  assign row_done   = ser_v_r && out_row.ready;
  // Take the next palette once the last row leaves, or when empty
  assign ser_load   = !ser_v_r || (row_done && row_r == bc1_pkg::ROW_LAST);
  assign pipe_ready = ser_load;

  always_comb begin
    ser_v_nxt = ser_v_r;
    row_nxt   = row_r;
    idx_nxt   = idx_r;
    if (ser_load) begin
      ser_v_nxt = pipe_valid;
      row_nxt   = 2'd0;
      idx_nxt   = pipe_data.index_bits;
    end else if (row_done) begin
      row_nxt = row_r + 2'd1;
      idx_nxt = {{bc1_pkg::ROW_IDX_W{1'b0}}, idx_r[31:bc1_pkg::ROW_IDX_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r <= 1'b0;
      row_r   <= 2'd0;
    end else begin
      ser_v_r <= ser_v_nxt;
      row_r   <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (ser_load) pal_r <= pipe_data.pal;
  end

  // Drive the result transaction from the serializer registers
  assign out_row.valid        = ser_v_r;
  assign out_row.row_number   = row_r;
  assign out_row.pixel_left   = pal_r[idx_r[1:0]];
  assign out_row.pixel_second = pal_r[idx_r[3:2]];
  assign out_row.pixel_third  = pal_r[idx_r[5:4]];
  assign out_row.pixel_right  = pal_r[idx_r[7:6]];
  assign out_row.last_row     = (row_r == bc1_pkg::ROW_LAST);

  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    row_done && row_r != bc1_pkg::ROW_LAST |=> ser_v_r && row_r == $past(row_r) + 2'd1)
    else $error("row counter skipped or block dropped mid-way");

  a_no_load_mid: assert property (@(posedge clk) disable iff (!rst_n)
    ser_v_r && row_r != bc1_pkg::ROW_LAST |-> !pipe_ready)
    else $error("palette accepted before last row left");

  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    row_done && row_r == bc1_pkg::ROW_LAST |=> row_r == 2'd0)
    else $error("new block does not start at row zero");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ser_v_r && !out_row.ready |=> ser_v_r && $stable(row_r) && $stable(idx_r))
    else $error("stalled row changed");

endmodule

`default_nettype wire

// ===== tb/sv/tb_bc1_block_decoder.sv =====
// tb_bc1_block_decoder: self-checking bench for the BC1 (DXT1) block decoder.
// Drives compressed blocks, predicts the four ARGB rows of each one and checks them.
// Depends on bc1_pkg, bc1_in_if / bc1_out_if and bc1_block_decoder.
`timescale 1ns / 1ps

module tb_bc1_block_decoder;

  // Cycles with no transaction on either channel before the run is abandoned
  localparam int unsigned QUIET_LIMIT = 2000;
  // Settle time after the last row: the block's first-row latency plus margin
  localparam int unsigned TAIL_CYCLES = 20;
  localparam bc1_pkg::pixel_t TRANSPARENT = '0;

  // One block waiting to go out; drain_first holds it until all rows have come
  typedef struct {
    bc1_pkg::blk_t blk;
    bit            drain_first;
  } pending_blk_t;

  // One predicted row of four pixels; px[0] is the left column
  typedef struct packed {
    logic [1:0]        row;
    logic [3:0][31:0]  px;
    logic              last;
  } row_expect_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bc1_in_if  block_ch ();
  bc1_out_if row_ch ();

  bc1_block_decoder i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_blk  (block_ch),
    .out_row (row_ch)
  );

  pending_blk_t blocks_to_send[$];
  row_expect_t  rows_due[$];

  bit          blk_taken = 1'b0;
  bit          row_taken = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned blocks_sent = 0;
  int unsigned four_color_blocks = 0;
  int unsigned rows_checked = 0;
  int unsigned mismatch_count = 0;

  always #1 clk = ~clk;

  // Expand an n-bit color channel to 8 bits by copying its top bits into the low end
  function automatic int unsigned widen_bits(input int unsigned v, input int unsigned n);
    int unsigned m;
    m = v & ((1 << n) - 1);
    return ((m << (8 - n)) | (m >> (2 * n - 8))) & 8'hFF;
  endfunction

  // Build the palette of one block and queue its four expected rows
  task automatic decode_block(input bc1_pkg::blk_t b);
    int unsigned     ca, cb, idx, sel;
    int unsigned     chan_a[3];
    int unsigned     chan_b[3];
    bc1_pkg::pixel_t pal[4];
    row_expect_t     r;
    ca  = b.endpoint_first;
    cb  = b.endpoint_second;
    idx = b.index_bits;
    chan_a[0] = widen_bits(ca >> 11, 5);
    chan_a[1] = widen_bits(ca >> 5, 6);
    chan_a[2] = widen_bits(ca, 5);
    chan_b[0] = widen_bits(cb >> 11, 5);
    chan_b[1] = widen_bits(cb >> 5, 6);
    chan_b[2] = widen_bits(cb, 5);
    pal[0] = {bc1_pkg::ALPHA_OPAQUE, 8'(chan_a[0]), 8'(chan_a[1]), 8'(chan_a[2])};
    pal[1] = {bc1_pkg::ALPHA_OPAQUE, 8'(chan_b[0]), 8'(chan_b[1]), 8'(chan_b[2])};
    if (ca > cb) begin
      // four opaque colors, inner ones at one and two thirds, truncated
      four_color_blocks++;
      pal[2] = {bc1_pkg::ALPHA_OPAQUE, 8'((2 * chan_a[0] + chan_b[0]) / 3),
                8'((2 * chan_a[1] + chan_b[1]) / 3), 8'((2 * chan_a[2] + chan_b[2]) / 3)};
      pal[3] = {bc1_pkg::ALPHA_OPAQUE, 8'((chan_a[0] + 2 * chan_b[0]) / 3),
                8'((chan_a[1] + 2 * chan_b[1]) / 3), 8'((chan_a[2] + 2 * chan_b[2]) / 3)};
    end else begin
      // equal or smaller first endpoint: midpoint color plus transparent black
      pal[2] = {bc1_pkg::ALPHA_OPAQUE, 8'((chan_a[0] + chan_b[0]) / 2),
                8'((chan_a[1] + chan_b[1]) / 2), 8'((chan_a[2] + chan_b[2]) / 2)};
      pal[3] = TRANSPARENT;
    end
    for (int row = 0; row < 4; row++) begin
      r.row  = 2'(row);
      r.last = (2'(row) == bc1_pkg::ROW_LAST);
      for (int col = 0; col < 4; col++) begin
        sel = (idx >> (2 * (row * 4 + col))) & 2'b11;
        r.px[col] = pal[sel];
      end
      rows_due.push_back(r);
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t ns: %s expected %h got %h", $time, what, want, got);
    end
  endtask

  task automatic add_block(input logic [15:0] ca, input logic [15:0] cb,
                           input logic [31:0] idx, input bit drain);
    pending_blk_t p;
    p.blk.endpoint_first  = ca;
    p.blk.endpoint_second = cb;
    p.blk.index_bits      = idx;
    p.drain_first         = drain;
    blocks_to_send.push_back(p);
  endtask

  // Random block: mostly free endpoints, with equal and adjacent pairs mixed in
  task automatic add_random_block(input bit drain);
    logic [15:0] ca, cb;
    logic [31:0] idx;
    ca = 16'($urandom);
    case ($urandom_range(0, 7))
      0:       cb = ca;
      1:       cb = ca + 16'(($urandom_range(0, 1) == 0) ? 1 : -1);
      default: cb = 16'($urandom);
    endcase
    idx = ($urandom_range(0, 5) == 0) ? {4{8'($urandom)}} : 32'($urandom);
    add_block(ca, cb, idx, drain);
  endtask

  // Sample both channels at the rising edge; predict on input, check on output
  always @(posedge clk) begin
    row_expect_t exp_row;
    blk_taken = rst_n && block_ch.valid && block_ch.ready;
    row_taken = rst_n && row_ch.valid && row_ch.ready;

    if (blk_taken) begin
      decode_block('{endpoint_first: block_ch.endpoint_first,
                     endpoint_second: block_ch.endpoint_second,
                     index_bits: block_ch.index_bits});
      blocks_sent++;
    end

    if (row_taken) begin
      if (rows_due.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: row transaction with nothing expected, row %0d",
                 $time, row_ch.row_number);
      end else begin
        exp_row = rows_due.pop_front();
        check_field("row_number", 32'(exp_row.row), 32'(row_ch.row_number));
        check_field("pixel_left", exp_row.px[0], row_ch.pixel_left);
        check_field("pixel_second", exp_row.px[1], row_ch.pixel_second);
        check_field("pixel_third", exp_row.px[2], row_ch.pixel_third);
        check_field("pixel_right", exp_row.px[3], row_ch.pixel_right);
        check_field("last_row", 32'(exp_row.last), 32'(row_ch.last_row));
        rows_checked++;
      end
    end

    // Watchdog: count cycles without any transaction once out of reset
    if (!rst_n || blk_taken || row_taken) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d idle cycles, %0d rows still due",
               quiet_cycles, rows_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Block driver: advance on the falling edge once the current block is taken.
  // Gaps run in stretches: every third group of 16 blocks goes back to back.
  always @(negedge clk) begin
    pending_blk_t nxt;
    if (!rst_n) begin
      block_ch.valid           <= 1'b0;
      block_ch.endpoint_first  <= '0;
      block_ch.endpoint_second <= '0;
      block_ch.index_bits      <= '0;
    end else if (!block_ch.valid || blk_taken) begin
      if (send_gap > 0) begin
        block_ch.valid <= 1'b0;
        send_gap--;
      end else if (blocks_to_send.size() != 0 &&
                   !(blocks_to_send[0].drain_first && rows_due.size() != 0)) begin
        nxt = blocks_to_send.pop_front();
        block_ch.endpoint_first  <= nxt.blk.endpoint_first;
        block_ch.endpoint_second <= nxt.blk.endpoint_second;
        block_ch.index_bits      <= nxt.blk.index_bits;
        block_ch.valid           <= 1'b1;
        send_gap = (((blocks_sent / 16) % 3) != 0) ? $urandom_range(0, 15) : 0;
      end else begin
        // hold off: queue empty, or a drain point waits for the last rows
        block_ch.valid <= 1'b0;
      end
    end
  end

  // Row sink: draw a stall after each row taken; some stretches never stall
  always @(negedge clk) begin
    if (!rst_n) begin
      row_ch.ready <= 1'b0;
    end else begin
      if (row_taken) begin
        stall_left = (((rows_checked / 24) % 3) != 1) ? $urandom_range(0, 15) : 0;
      end
      if (stall_left > 0) begin
        row_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        row_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    // Directed blocks: endpoint extremes, the compare boundary, all index patterns
    add_block(16'hFFFF, 16'h0000, 32'hE4E4_E4E4, 1'b0);  // four colors, every index
    add_block(16'h0000, 16'hFFFF, 32'hE4E4_E4E4, 1'b0);  // three colors + transparent
    add_block(16'h1234, 16'h1234, 32'hFFFF_FFFF, 1'b0);  // equal endpoints, all index 3
    add_block(16'h0000, 16'h0000, 32'h0000_0000, 1'b0);
    add_block(16'hFFFF, 16'hFFFF, 32'h5555_5555, 1'b0);
    add_block(16'hFFFF, 16'hFFFE, 32'hAAAA_AAAA, 1'b0);
    add_block(16'hFFFF, 16'hFFFE, 32'hFFFF_FFFF, 1'b0);
    add_block(16'h8000, 16'h7FFF, 32'h1B1B_1B1B, 1'b0);  // just above: four colors
    add_block(16'h7FFF, 16'h8000, 32'h1B1B_1B1B, 1'b0);  // just below: three colors
    add_block(16'hF800, 16'h001F, 32'h39C6_39C6, 1'b0);  // pure red against pure blue
    add_block(16'h07E0, 16'h0000, 32'hC6C6_C6C6, 1'b0);  // pure green against black
    add_block(16'h001F, 16'h07E0, 32'hFF00_FF00, 1'b0);
    add_block(16'hAAAA, 16'h5555, 32'h0123_4567, 1'b0);
    add_block(16'h5555, 16'hAAAA, 32'h89AB_CDEF, 1'b0);
    add_block(16'h0001, 16'h0000, 32'hFEDC_BA98, 1'b0);

    // Random blocks; the first and every 25th wait for all rows to drain
    for (int n = 0; n < 100; n++) begin
      add_random_block(n % 25 == 0);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (blocks_to_send.size() != 0 || block_ch.valid || rows_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (rows_due.size() != 0) begin
      mismatch_count++;
      $display("%0t ns: %0d expected rows never came", $time, rows_due.size());
    end

    $display("covered %0d blocks (%0d four-color, %0d three-color), %0d rows checked",
             blocks_sent, four_color_blocks, blocks_sent - four_color_blocks, rows_checked);
    $display("%0d field mismatches or stray rows", mismatch_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/bc1_pkg.sv
hw/rtl/bc1_if.sv
hw/rtl/bc1_pal_pipe.sv
hw/rtl/bc1_block_decoder.sv
tb/sv/tb_bc1_block_decoder.sv
